>>> design/glpw_pkg.sv
// glpw_pkg: shared types, constants and helpers of the grid line point walker
// used by the interfaces, the controller, the datapath and the top level
// no dependencies
package glpw_pkg;

  // grid geometry
  localparam int GRID_SIZE = 16;
  localparam int COORD_W   = 4;
  localparam int KIND_W    = 2;
  localparam int STEP_W    = 5;

  // result kinds
  localparam logic [KIND_W-1:0] MARK_PATH  = 2'd0;
  localparam logic [KIND_W-1:0] MARK_START = 2'd1;
  localparam logic [KIND_W-1:0] MARK_END   = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [STEP_W-1:0]  step_t;

  // emit phase of one line
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PATH,
    PH_START,
    PH_END
  } phase_t;

  // input beat payload
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_beat_t;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  step;
    logic  emit;
    kind_t kind;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_d_zero;
    logic path_last;
    logic out_free;
  } dp_stat_t;

  // saturate a coordinate to the grid
  function automatic coord_t clamp_coord(input coord_t v);
    logic [STEP_W-1:0] lim;
    lim = STEP_W'(GRID_SIZE - 1);
    if ({1'b0, v} > lim) begin
      clamp_coord = COORD_W'(GRID_SIZE - 1);
    end else begin
      clamp_coord = v;
    end
  endfunction

endpackage

>>> design/glpw_if.sv
// glpw_if: valid/ready channel interfaces for endpoint beats and result beats
// depends on glpw_pkg
interface glpw_in_if;
  import glpw_pkg::*;

  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink (input valid, input start_x, input start_y, input end_x,
                input end_y, output ready);
endinterface

interface glpw_out_if;
  import glpw_pkg::*;

  logic   valid;
  logic   ready;
  coord_t cell_x;
  coord_t cell_y;
  kind_t  mark_kind;
  logic   last_of_line;

  modport source (output valid, output cell_x, output cell_y, output mark_kind,
                  output last_of_line, input ready);
  modport sink (input valid, input cell_x, input cell_y, input mark_kind,
                input last_of_line, output ready);
endinterface

>>> design/glpw_ctrl.sv
// glpw_ctrl: phase state machine that sequences path cells and markers
// depends on glpw_pkg
module glpw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  glpw_pkg::dp_stat_t    stat,
  output glpw_pkg::ctrl_cmd_t   cmd
);
  import glpw_pkg::*;

  phase_t state_r;
  phase_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PH_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.in_d_zero ? PH_START : PH_PATH;
        end
      end
      PH_PATH: begin
        if (stat.out_free && stat.path_last) begin
          state_nxt = PH_START;
        end
      end
      PH_START: begin
        if (stat.out_free) begin
          state_nxt = PH_END;
        end
      end
      PH_END: begin
        if (stat.out_free) begin
          state_nxt = PH_IDLE;
        end
      end
      default: state_nxt = PH_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.kind = MARK_PATH;
    case (state_r)
      PH_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      PH_PATH: begin
        cmd.step = stat.out_free;
        cmd.emit = stat.out_free;
        cmd.kind = MARK_PATH;
      end
      PH_START: begin
        cmd.emit = stat.out_free;
        cmd.kind = MARK_START;
      end
      PH_END: begin
        cmd.emit = stat.out_free;
        cmd.kind = MARK_END;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // end marker closes the line
  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PH_END && cmd.emit) |=> (state_r == PH_IDLE))
    else $error("end marker did not return to idle");

  // a path step only happens in the path phase, with the path kind
  a_step_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (state_r == PH_PATH && cmd.kind == MARK_PATH))
    else $error("step outside path phase");

endmodule

>>> design/glpw_dp.sv
// glpw_dp: endpoint hold, remainder accumulators and output register
// depends on glpw_pkg
module glpw_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  glpw_pkg::in_beat_t    in_beat,
  input  glpw_pkg::ctrl_cmd_t   cmd,
  output glpw_pkg::dp_stat_t    stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output glpw_pkg::coord_t      out_cell_x,
  output glpw_pkg::coord_t      out_cell_y,
  output glpw_pkg::kind_t       out_mark_kind,
  output logic                  out_last_of_line
);
  import glpw_pkg::*;

  // held line description
  coord_t sx_r, sy_r, ex_r, ey_r;
  coord_t mag_x_r, mag_y_r;
  logic   neg_x_r, neg_y_r;
  step_t  total_r, step_r;
  coord_t off_x_r, off_y_r;
  step_t  rem_x_r, rem_y_r;

  // output register
  logic   out_valid_r;
  coord_t cell_x_r, cell_y_r;
  kind_t  kind_r;
  logic   last_r;

  // load side
  coord_t ax, ay, bx, by;
  logic   in_neg_x, in_neg_y;
  coord_t in_mag_x, in_mag_y;
  step_t  in_total;

  // step side
  logic [STEP_W:0] sum_x, sum_y;
  logic   carry_x, carry_y;
  step_t  rem_x_nxt, rem_y_nxt;
  coord_t off_x_nxt, off_y_nxt;
  coord_t pos_x, pos_y;
  coord_t res_x, res_y;

  // endpoint saturation and deltas
  always_comb begin
    ax       = clamp_coord(in_beat.start_x);
    ay       = clamp_coord(in_beat.start_y);
    bx       = clamp_coord(in_beat.end_x);
    by       = clamp_coord(in_beat.end_y);
    in_neg_x = bx < ax;
    in_neg_y = by < ay;
    in_mag_x = in_neg_x ? (ax - bx) : (bx - ax);
    in_mag_y = in_neg_y ? (ay - by) : (by - ay);
    in_total = STEP_W'(in_mag_x) + STEP_W'(in_mag_y);
  end

  // accumulate and carry on each axis
  always_comb begin
    sum_x     = {1'b0, rem_x_r} + (STEP_W+1)'(mag_x_r);
    sum_y     = {1'b0, rem_y_r} + (STEP_W+1)'(mag_y_r);
    carry_x   = sum_x >= {1'b0, total_r};
    carry_y   = sum_y >= {1'b0, total_r};
    rem_x_nxt = carry_x ? STEP_W'(sum_x - {1'b0, total_r}) : STEP_W'(sum_x);
    rem_y_nxt = carry_y ? STEP_W'(sum_y - {1'b0, total_r}) : STEP_W'(sum_y);
    off_x_nxt = off_x_r + COORD_W'(carry_x);
    off_y_nxt = off_y_r + COORD_W'(carry_y);
    // negative direction rounds the exact position down
    pos_x = neg_x_r ? (sx_r - off_x_nxt - COORD_W'(rem_x_nxt != '0)) : (sx_r + off_x_nxt);
    pos_y = neg_y_r ? (sy_r - off_y_nxt - COORD_W'(rem_y_nxt != '0)) : (sy_r + off_y_nxt);
  end

  // result selection
  always_comb begin
    case (cmd.kind)
      MARK_START: begin
        res_x = sx_r;
        res_y = sy_r;
      end
      MARK_END: begin
        res_x = ex_r;
        res_y = ey_r;
      end
      default: begin
        res_x = pos_x;
        res_y = pos_y;
      end
    endcase
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r    <= '0;
      sy_r    <= '0;
      ex_r    <= '0;
      ey_r    <= '0;
      mag_x_r <= '0;
      mag_y_r <= '0;
      neg_x_r <= 1'b0;
      neg_y_r <= 1'b0;
      total_r <= '0;
      step_r  <= '0;
      off_x_r <= '0;
      off_y_r <= '0;
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (cmd.load) begin
      sx_r    <= ax;
      sy_r    <= ay;
      ex_r    <= bx;
      ey_r    <= by;
      mag_x_r <= in_mag_x;
      mag_y_r <= in_mag_y;
      neg_x_r <= in_neg_x;
      neg_y_r <= in_neg_y;
      total_r <= in_total;
      step_r  <= '0;
      off_x_r <= '0;
      off_y_r <= '0;
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (cmd.step) begin
      step_r  <= step_r + 1'b1;
      off_x_r <= off_x_nxt;
      off_y_r <= off_y_nxt;
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cell_x_r <= res_x;
      cell_y_r <= res_y;
      kind_r   <= cmd.kind;
      last_r   <= (cmd.kind == MARK_END);
    end
  end

  // status
  always_comb begin
    stat.in_d_zero = (in_total == '0);
    stat.path_last = ((step_r + 1'b1) == total_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_cell_x       = cell_x_r;
  assign out_cell_y       = cell_y_r;
  assign out_mark_kind    = kind_r;
  assign out_last_of_line = last_r;

  // step count never passes the line length
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= total_r)
    else $error("step index beyond line length");

  // remainders stay below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != '0) |-> (rem_x_r < total_r && rem_y_r < total_r))
    else $error("remainder not below line length");

  // a finished path lands exactly on the end point
  a_path_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != '0 && step_r == total_r) |->
      (off_x_r == mag_x_r && off_y_r == mag_y_r && rem_x_r == '0 && rem_y_r == '0))
    else $error("path did not reach end point");

endmodule

>>> design/grid_line_point_walker.sv
// grid_line_point_walker: top level, joins controller and datapath to the channels
// depends on glpw_pkg, glpw_if, glpw_ctrl and glpw_dp
//
// Each input beat is a start and an end point on a 16 by 16 grid (coordinates
// above the grid edge saturate). The block walks d = |dx| + |dy| steps and emits
// one path cell per step, each coordinate rounded down from the exact position via a
// remainder accumulator, then the start marker and the end marker, the latter with last_of_line set.
// Results leave at one per cycle through an output register while out_ready
// allows, after the accept state; a line gives d + 2 results. The next line
// is accepted as soon as the end marker has entered the output register,
// while that marker still waits to be taken.
module grid_line_point_walker (
  input logic        clk,
  input logic        rst_n,
  glpw_in_if.sink    in_ch,
  glpw_out_if.source out_ch
);
  import glpw_pkg::*;

  in_beat_t  in_beat;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // input beat payload
  always_comb begin
    in_beat.start_x = in_ch.start_x;
    in_beat.start_y = in_ch.start_y;
    in_beat.end_x   = in_ch.end_x;
    in_beat.end_y   = in_ch.end_y;
  end

  // sequencing
  glpw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and output register
  glpw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_beat          (in_beat),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_cell_x       (out_ch.cell_x),
    .out_cell_y       (out_ch.cell_y),
    .out_mark_kind    (out_ch.mark_kind),
    .out_last_of_line (out_ch.last_of_line)
  );

endmodule
